// ===== rtl/sirt_pkg.sv =====
// Package for the signed integer to radix text block.
// Register reset values, sign codes, sequencer states and the symbol lookup.
// No dependencies.
package sirt_pkg;

	localparam int SIRT_MAX_SYMBOLS = 16;
	localparam int SIRT_MAX_DIGITS  = 32;
	localparam int SIRT_VALUE_W     = 32;
	localparam int SIRT_RADIX_W     = 5;
	localparam int SIRT_SYM_W       = 8;
	localparam int SIRT_SYM_IDX_W   = 4;
	localparam int SIRT_ALPHA_W     = 64;

	localparam logic [SIRT_SYM_W-1:0] SIGN_PLUS  = 8'h2B;
	localparam logic [SIRT_SYM_W-1:0] SIGN_MINUS = 8'h2D;

	localparam logic [SIRT_RADIX_W-1:0] RESET_RADIX      = 5'd10;
	localparam logic [SIRT_ALPHA_W-1:0] RESET_ALPHA_LOW  = 64'h3736353433323130;
	localparam logic [SIRT_ALPHA_W-1:0] RESET_ALPHA_HIGH = 64'h4645444342413938;

	// register indexes (paddr[4:3])
	localparam logic [1:0] REG_RADIX      = 2'd0;
	localparam logic [1:0] REG_ALPHA_LOW  = 2'd1;
	localparam logic [1:0] REG_ALPHA_HIGH = 2'd2;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CHECK,
		ST_DIV_START,
		ST_DIV_WAIT,
		ST_EMIT_SIGN,
		ST_EMIT
	} sirt_state_t;

	typedef struct packed {
		logic [SIRT_VALUE_W-1:0] quotient;
		logic [SIRT_RADIX_W-1:0] remainder;
		logic                    done;
	} sirt_div_rsp_t;

	function automatic logic [SIRT_SYM_W-1:0] sym_at(
		input logic [SIRT_ALPHA_W-1:0]   lo,
		input logic [SIRT_ALPHA_W-1:0]   hi,
		input logic [SIRT_SYM_IDX_W-1:0] idx
	);
		logic [SIRT_ALPHA_W-1:0] word;
		word = idx[3] ? hi : lo;
		return word[idx[2:0]*SIRT_SYM_W +: SIRT_SYM_W];
	endfunction

endpackage

// ===== rtl/sirt_div.sv =====
// Restoring divider, one quotient bit per cycle, 32-bit dividend by a
// divisor of at most 16. Depends on sirt_pkg.
module sirt_div
	import sirt_pkg::*;
(
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	input  logic [SIRT_VALUE_W-1:0] dividend,
	input  logic [SIRT_RADIX_W-1:0] divisor,
	output sirt_div_rsp_t           rsp
);

	logic [SIRT_VALUE_W-1:0] quo_q;
	logic [SIRT_RADIX_W-1:0] rem_q;
	logic [SIRT_RADIX_W-1:0] dvs_q;
	logic [4:0]              cnt_q;
	logic                    busy_q;
	logic                    done_q;
	logic [SIRT_RADIX_W-1:0] shifted;
	logic                    fits;

	// remainder stays below the divisor (at most 16), so four bits carry it
	assign shifted = {rem_q[3:0], quo_q[SIRT_VALUE_W-1]};
	assign fits    = (shifted >= dvs_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == 5'd31);
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 5'd1;
				if (cnt_q == 5'd31)
					busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[SIRT_VALUE_W-2:0], fits};
			rem_q <= fits ? (shifted - dvs_q) : shifted;
		end
	end

	assign rsp.quotient  = quo_q;
	assign rsp.remainder = rem_q;
	assign rsp.done      = done_q;

endmodule

// ===== rtl/signed_integer_to_radix_text_core.sv =====
// Flow: the alphabet check, then each digit on the shared bit-serial divider,
// then one output beat per cycle while the output is not stalled. One item at
// a time: in_stall is high from acceptance until the last beat is loaded into
// the output register.
// arst_n clears the sequencer and output valid, and sets the registers to
// radix 10 with alphabet "0123456789ABCDEF".
module signed_integer_to_radix_text_core
	import sirt_pkg::*;
#(
	parameter int MAX_SYMBOLS = SIRT_MAX_SYMBOLS
) (
	input  logic                    clk,
	input  logic                    arst_n,
	// config port
	input  logic                    psel,
	input  logic                    penable,
	input  logic                    pwrite,
	input  logic [4:0]              paddr,
	input  logic [SIRT_ALPHA_W-1:0] pwdata,
	output logic [SIRT_ALPHA_W-1:0] prdata,
	output logic                    pready,
	// input channel
	input  logic                    in_valid,
	output logic                    in_stall,
	input  logic signed [SIRT_VALUE_W-1:0] value,
	// output channel
	output logic                    out_valid,
	input  logic                    out_stall,
	output logic [SIRT_SYM_W-1:0]   symbol,
	output logic                    last
);

	localparam int DIG_W = $clog2(MAX_SYMBOLS);
	localparam int ND_W  = $clog2(SIRT_MAX_DIGITS);

	logic [SIRT_RADIX_W-1:0] radix_q;
	logic [SIRT_ALPHA_W-1:0] alpha_lo_q;
	logic [SIRT_ALPHA_W-1:0] alpha_hi_q;

	sirt_state_t state_q, state_d;

	logic                    neg_q;
	logic [SIRT_VALUE_W-1:0] mag_q;
	logic [DIG_W-1:0]        idx_q;
	logic [ND_W:0]           nd_q;
	logic [ND_W-1:0]         k_q;
	logic [DIG_W-1:0]        digits_q [SIRT_MAX_DIGITS];

	logic                    out_valid_q;
	logic [SIRT_SYM_W-1:0]   symbol_q;
	logic                    last_q;

	logic                    cfg_wr;
	logic                    range_ok;
	logic                    idx_last;
	logic                    sym_bad;
	logic [SIRT_SYM_W-1:0]   cur_sym;
	logic                    div_start;
	logic                    div_final;
	logic                    out_free;
	logic                    load_out;
	logic [SIRT_SYM_W-1:0]   load_sym;
	logic                    load_last;
	sirt_div_rsp_t           div_rsp;

	// ---------------- config registers
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radix_q    <= RESET_RADIX;
			alpha_lo_q <= RESET_ALPHA_LOW;
			alpha_hi_q <= RESET_ALPHA_HIGH;
		end else if (cfg_wr) begin
			unique case (paddr[4:3])
				REG_RADIX:      radix_q    <= pwdata[SIRT_RADIX_W-1:0];
				REG_ALPHA_LOW:  alpha_lo_q <= pwdata;
				REG_ALPHA_HIGH: alpha_hi_q <= pwdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[4:3])
			REG_RADIX:      prdata = {{(SIRT_ALPHA_W-SIRT_RADIX_W){1'b0}}, radix_q};
			REG_ALPHA_LOW:  prdata = alpha_lo_q;
			REG_ALPHA_HIGH: prdata = alpha_hi_q;
			default:        prdata = '0;
		endcase
	end

	// ---------------- alphabet check, one symbol against all later ones per cycle
	assign range_ok = (radix_q >= 5'd2) && (radix_q <= SIRT_RADIX_W'(MAX_SYMBOLS));
	assign idx_last = (SIRT_RADIX_W'(idx_q) == (radix_q - 5'd1));
	assign cur_sym  = sym_at(alpha_lo_q, alpha_hi_q, SIRT_SYM_IDX_W'(idx_q));

	always_comb begin
		sym_bad = (cur_sym == '0) || (cur_sym == SIGN_PLUS) || (cur_sym == SIGN_MINUS);
		for (int j = 0; j < MAX_SYMBOLS; j++) begin
			if ((SIRT_RADIX_W'(j) > SIRT_RADIX_W'(idx_q)) && (SIRT_RADIX_W'(j) < radix_q)
					&& (sym_at(alpha_lo_q, alpha_hi_q, SIRT_SYM_IDX_W'(j)) == cur_sym))
				sym_bad = 1'b1;
		end
	end

	// ---------------- shared divider
	sirt_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (mag_q),
		.divisor  (radix_q),
		.rsp      (div_rsp)
	);

	assign div_final = (div_rsp.quotient == '0) || (nd_q == (ND_W+1)'(SIRT_MAX_DIGITS - 1));

	// ---------------- sequencer
	assign out_free = !out_valid_q || !out_stall;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:
				if (in_valid)
					state_d = range_ok ? ST_CHECK : ST_IDLE;
			ST_CHECK:
				if (sym_bad)
					state_d = ST_IDLE;
				else if (idx_last)
					state_d = ST_DIV_START;
			ST_DIV_START:
				state_d = ST_DIV_WAIT;
			ST_DIV_WAIT:
				if (div_rsp.done)
					state_d = div_final ? (neg_q ? ST_EMIT_SIGN : ST_EMIT) : ST_DIV_START;
			ST_EMIT_SIGN:
				if (out_free)
					state_d = ST_EMIT;
			ST_EMIT:
				if (out_free && (k_q == '0))
					state_d = ST_IDLE;
			default:
				state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		in_stall  = (state_q != ST_IDLE);
		div_start = (state_q == ST_DIV_START);
		load_out  = 1'b0;
		load_sym  = SIGN_MINUS;
		load_last = 1'b0;
		unique case (state_q)
			ST_EMIT_SIGN: load_out = out_free;
			ST_EMIT: begin
				load_out  = out_free;
				load_sym  = sym_at(alpha_lo_q, alpha_hi_q, SIRT_SYM_IDX_W'(digits_q[k_q]));
				load_last = (k_q == '0);
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_d;
	end

	// working registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				neg_q <= value[SIRT_VALUE_W-1];
				mag_q <= value[SIRT_VALUE_W-1] ? (SIRT_VALUE_W'(0) - SIRT_VALUE_W'(value))
				                               : SIRT_VALUE_W'(value);
				idx_q <= '0;
				nd_q  <= '0;
			end
			ST_CHECK:
				idx_q <= idx_q + DIG_W'(1);
			ST_DIV_WAIT:
				if (div_rsp.done) begin
					digits_q[nd_q[ND_W-1:0]] <= div_rsp.remainder[DIG_W-1:0];
					mag_q <= div_rsp.quotient;
					nd_q  <= nd_q + (ND_W+1)'(1);
					k_q   <= nd_q[ND_W-1:0];
				end
			ST_EMIT:
				if (out_free)
					k_q <= k_q - ND_W'(1);
			default: ;
		endcase
	end

	// ---------------- output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (load_out)
			out_valid_q <= 1'b1;
		else if (!out_stall)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			symbol_q <= load_sym;
			last_q   <= load_last;
		end
	end

	assign out_valid = out_valid_q;
	assign symbol    = symbol_q;
	assign last      = last_q;

endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 100ps
// Testbench for signed_integer_to_radix_text_core: predicts the text of each value
// under the current radix and alphabet and checks every output beat. Uses sirt_pkg.
module tb_top
	import sirt_pkg::*;
();

	localparam int unsigned IDLE_PERCENT   = 31;
	localparam int unsigned RANDOM_ITEMS   = 380;
	localparam int unsigned CALM_PHASE     = 4;
	localparam int unsigned SETTLE_CYCLES  = 40;
	localparam int unsigned WATCHDOG_LIMIT = 20000;
	localparam logic [1:0]  REG_SPARE      = 2'd3;

	typedef enum logic [2:0] {
		SETUP_GOOD,
		SETUP_DEFAULT,
		SETUP_DUP,
		SETUP_PLUS,
		SETUP_MINUS,
		SETUP_ZERO
	} setup_kind_t;

	typedef struct packed {
		logic [SIRT_SYM_W-1:0] symbol;
		logic                  last;
	} text_beat_t;

	class text_scoreboard;
		logic [SIRT_RADIX_W-1:0] radix;
		logic [SIRT_ALPHA_W-1:0] alpha_lo;
		logic [SIRT_ALPHA_W-1:0] alpha_hi;
		text_beat_t              pending_text[$];
		int unsigned             mismatches;

		function new();
			radix      = RESET_RADIX;
			alpha_lo   = RESET_ALPHA_LOW;
			alpha_hi   = RESET_ALPHA_HIGH;
			mismatches = 0;
		endfunction

		function void flag_mismatch(string msg);
			mismatches++;
			if (mismatches <= 10)
				$display("%t mismatch: %s", $realtime, msg);
		endfunction

		function void set_register(logic [1:0] idx, logic [SIRT_ALPHA_W-1:0] data);
			case (idx)
				REG_RADIX:      radix = data[SIRT_RADIX_W-1:0];
				REG_ALPHA_LOW:  alpha_lo = data;
				REG_ALPHA_HIGH: alpha_hi = data;
				default: ;
			endcase
		endfunction

		function logic [SIRT_ALPHA_W-1:0] register_value(logic [1:0] idx);
			case (idx)
				REG_RADIX:      return SIRT_ALPHA_W'(radix);
				REG_ALPHA_LOW:  return alpha_lo;
				default:        return alpha_hi;
			endcase
		endfunction

		function logic [SIRT_SYM_W-1:0] symbol_of(logic [SIRT_SYM_IDX_W-1:0] idx);
			logic [SIRT_ALPHA_W-1:0] word;
			word = idx[3] ? alpha_hi : alpha_lo;
			return SIRT_SYM_W'(word >> (8 * idx[2:0]));
		endfunction

		function bit alphabet_valid();
			logic [SIRT_SYM_W-1:0] s;
			if (radix < 2 || radix > SIRT_MAX_SYMBOLS)
				return 1'b0;
			for (int unsigned i = 0; i < radix; i++) begin
				s = symbol_of(i[3:0]);
				if (s == '0 || s == SIGN_PLUS || s == SIGN_MINUS)
					return 1'b0;
				for (int unsigned j = i + 1; j < radix; j++)
					if (symbol_of(j[3:0]) == s)
						return 1'b0;
			end
			return 1'b1;
		endfunction

		function int unsigned outstanding();
			return pending_text.size();
		endfunction

		// renders one accepted value into the expected beats
		function void note_value(logic [SIRT_VALUE_W-1:0] raw);
			logic [SIRT_VALUE_W-1:0] mag;
			logic [SIRT_SYM_W-1:0]   digit_syms[$];
			text_beat_t              b;
			if (!alphabet_valid())
				return;
			mag = raw[SIRT_VALUE_W-1] ? -raw : raw;
			do begin
				digit_syms.push_front(symbol_of(SIRT_SYM_IDX_W'(mag % radix)));
				mag = mag / radix;
			end while (mag != 0);
			if (raw[SIRT_VALUE_W-1]) begin
				b.symbol = SIGN_MINUS;
				b.last   = 1'b0;
				pending_text.push_back(b);
			end
			foreach (digit_syms[k]) begin
				b.symbol = digit_syms[k];
				b.last   = (k == digit_syms.size() - 1);
				pending_text.push_back(b);
			end
		endfunction

		function void check_beat(logic [SIRT_SYM_W-1:0] sym, logic fin);
			text_beat_t want;
			if (pending_text.size() == 0) begin
				flag_mismatch($sformatf("unexpected beat: symbol %02h last %b", sym, fin));
				return;
			end
			want = pending_text.pop_front();
			if (sym !== want.symbol)
				flag_mismatch($sformatf("symbol: expected %02h, got %02h", want.symbol, sym));
			if (fin !== want.last)
				flag_mismatch($sformatf("last: expected %b, got %b", want.last, fin));
		endfunction
	endclass

	logic                           clk       = 1'b0;
	logic                           arst_n    = 1'b0;
	logic                           psel      = 1'b0;
	logic                           penable   = 1'b0;
	logic                           pwrite    = 1'b0;
	logic [4:0]                     paddr     = '0;
	logic [SIRT_ALPHA_W-1:0]        pwdata    = '0;
	logic [SIRT_ALPHA_W-1:0]        prdata;
	logic                           pready;
	logic                           in_valid  = 1'b0;
	logic                           in_stall;
	logic signed [SIRT_VALUE_W-1:0] value     = '0;
	logic                           out_valid;
	logic                           out_stall = 1'b0;
	logic [SIRT_SYM_W-1:0]          symbol;
	logic                           last;
	bit                             calm      = 1'b0;

	text_scoreboard board = new();

	signed_integer_to_radix_text_core DUT (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.value(value),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.symbol(symbol),
		.last(last)
	);

	always #2 clk = ~clk;

	function automatic bit take_break();
		return !calm && ($urandom_range(99) < IDLE_PERCENT);
	endfunction

	// magnitudes of random bit length, plus the most negative, the largest and zero
	function automatic logic [SIRT_VALUE_W-1:0] pick_value();
		logic [SIRT_VALUE_W-1:0] mag;
		int unsigned             bits;
		case ($urandom_range(19))
			0: return 32'h8000_0000;
			1: return 32'h7FFF_FFFF;
			2: return '0;
			default: begin
				bits = $urandom_range(1, 32);
				mag  = $urandom;
				if (bits < 32)
					mag &= (32'h1 << bits) - 1;
				return $urandom_range(1) ? -mag : mag;
			end
		endcase
	endfunction

	// back-to-back transfers are fine; the caller drops psel afterwards
	task automatic apb_cycle(input logic [1:0] idx, input logic wr,
			input logic [SIRT_ALPHA_W-1:0] data, output logic [SIRT_ALPHA_W-1:0] rdata);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= wr;
		paddr   <= {idx, 3'b000};
		pwdata  <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		rdata = prdata;
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [SIRT_ALPHA_W-1:0] data);
		logic [SIRT_ALPHA_W-1:0] back;
		logic [SIRT_ALPHA_W-1:0] want;
		apb_cycle(idx, 1'b1, data, back);
		board.set_register(idx, data);
		if (idx == REG_SPARE)
			return;
		apb_cycle(idx, 1'b0, '0, back);
		want = board.register_value(idx);
		if (idx == REG_RADIX ? back[SIRT_RADIX_W-1:0] !== want[SIRT_RADIX_W-1:0] : back !== want)
			board.flag_mismatch($sformatf("register %0d read back %h, expected %h",
				idx, back, want));
	endtask

	task automatic apply_setup(input setup_kind_t kind, input logic [SIRT_RADIX_W-1:0] rdx,
			input bit poke_spare);
		logic [SIRT_SYM_W-1:0]   sym [SIRT_MAX_SYMBOLS];
		logic [255:0]            taken;
		logic [SIRT_SYM_W-1:0]   s;
		logic [SIRT_ALPHA_W-1:0] lo;
		logic [SIRT_ALPHA_W-1:0] hi;
		int unsigned             n, a, b;
		taken             = '0;
		taken[0]          = 1'b1;
		taken[SIGN_PLUS]  = 1'b1;
		taken[SIGN_MINUS] = 1'b1;
		n = (rdx > SIRT_MAX_SYMBOLS) ? SIRT_MAX_SYMBOLS : rdx;
		// symbols beyond the radix are left as junk on purpose
		for (int unsigned i = 0; i < SIRT_MAX_SYMBOLS; i++) begin
			if (i < n) begin
				do s = SIRT_SYM_W'($urandom); while (taken[s]);
				taken[s] = 1'b1;
				sym[i]   = s;
			end else begin
				sym[i] = SIRT_SYM_W'($urandom);
			end
		end
		a = 0;
		b = 0;
		if (n >= 2) begin
			a = $urandom_range(n - 2);
			b = $urandom_range(n - 1, a + 1);
		end
		case (kind)
			SETUP_DUP:   sym[b] = sym[a];
			SETUP_PLUS:  sym[a] = SIGN_PLUS;
			SETUP_MINUS: sym[b] = SIGN_MINUS;
			SETUP_ZERO:  sym[b] = '0;
			default: ;
		endcase
		for (int unsigned i = 0; i < 8; i++) begin
			lo[i*8 +: 8] = sym[i];
			hi[i*8 +: 8] = sym[i+8];
		end
		if (kind == SETUP_DEFAULT) begin
			lo = RESET_ALPHA_LOW;
			hi = RESET_ALPHA_HIGH;
		end
		write_reg(REG_RADIX, SIRT_ALPHA_W'(rdx));
		write_reg(REG_ALPHA_LOW, lo);
		write_reg(REG_ALPHA_HIGH, hi);
		if (poke_spare)
			write_reg(REG_SPARE, {$urandom, $urandom});
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	task automatic send_value(input logic [SIRT_VALUE_W-1:0] v);
		if (take_break()) begin
			in_valid <= 1'b0;
			do @(posedge clk); while (take_break());
		end
		in_valid <= 1'b1;
		value    <= v;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		board.note_value(v);
	endtask

	// a rejected value shows nothing outside, so allow for the radix check afterwards
	task automatic settle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (board.outstanding() != 0 || in_stall || out_valid) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	initial begin : receiver
		forever begin
			@(posedge clk);
			if (arst_n && out_valid && !out_stall)
				board.check_beat(symbol, last);
			out_stall <= take_break();
		end
	end

	initial begin : watchdog
		int unsigned quiet;
		quiet = 0;
		while (quiet < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((in_valid && !in_stall) || (out_valid && !out_stall) || (psel && penable))
				quiet = 0;
			else
				quiet++;
		end
		$display("** signed_integer_to_radix_text_core: FAILED **");
		$finish;
	end

	initial begin : stimulus
		logic [SIRT_VALUE_W-1:0] plain_cases [9];
		setup_kind_t             kind;
		logic [SIRT_RADIX_W-1:0] rdx;
		int unsigned             n, r, good_items, phase;
		plain_cases = '{32'd0, 32'd1, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
			32'd9, 32'd10, 32'hFFFF_FFF6, 32'd255};
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset alphabet, decimal
		foreach (plain_cases[k])
			send_value(plain_cases[k]);

		// binary: longest text, including the most negative value
		settle();
		apply_setup(SETUP_DEFAULT, 5'd2, 1'b0);
		send_value(32'h8000_0000);
		send_value(32'h7FFF_FFFF);
		send_value(32'hFFFF_FFFF);
		send_value(32'd0);
		send_value(32'd5);

		// full sixteen-symbol alphabet; the write beyond the last register must not stick
		settle();
		apply_setup(SETUP_GOOD, 5'd16, 1'b1);
		send_value(32'h8000_0000);
		send_value(32'hDEAD_BEEF);
		send_value(32'd1234);

		// each way the alphabet can be rejected
		for (int unsigned k = 0; k < 8; k++) begin
			settle();
			case (k)
				0: apply_setup(SETUP_GOOD, 5'd0, 1'b0);
				1: apply_setup(SETUP_GOOD, 5'd1, 1'b0);
				2: apply_setup(SETUP_GOOD, 5'd17, 1'b0);
				3: apply_setup(SETUP_GOOD, 5'd31, 1'b0);
				4: apply_setup(SETUP_DUP, 5'd16, 1'b0);
				5: apply_setup(SETUP_PLUS, 5'd2, 1'b0);
				6: apply_setup(SETUP_MINUS, 5'd10, 1'b0);
				default: apply_setup(SETUP_ZERO, 5'd16, 1'b0);
			endcase
			send_value(pick_value());
		end

		good_items = 0;
		phase      = 0;
		while (good_items < RANDOM_ITEMS) begin
			settle();
			case ($urandom_range(3))
				0: rdx = 5'd2;
				1: rdx = 5'd16;
				default: rdx = $urandom_range(2, 16);
			endcase
			kind = SETUP_GOOD;
			r    = $urandom_range(99);
			if (phase != CALM_PHASE) begin
				if (r < 55)      kind = SETUP_GOOD;
				else if (r < 67) kind = SETUP_DEFAULT;
				else if (r < 72) kind = SETUP_DUP;
				else if (r < 77) kind = SETUP_PLUS;
				else if (r < 82) kind = SETUP_MINUS;
				else if (r < 87) kind = SETUP_ZERO;
				else if (r < 93) rdx = $urandom_range(1);
				else             rdx = $urandom_range(17, 31);
			end
			calm = (phase == CALM_PHASE);
			apply_setup(kind, rdx, $urandom_range(4) == 0);
			if (calm)
				n = 60;
			else if (board.alphabet_valid())
				n = $urandom_range(10, 30);
			else
				n = $urandom_range(2, 5);
			repeat (n) begin
				send_value(pick_value());
				if (board.alphabet_valid())
					good_items++;
			end
			phase++;
		end
		calm = 1'b0;

		settle();
		if (board.mismatches == 0 && board.outstanding() == 0)
			$display("** signed_integer_to_radix_text_core: PASSED **");
		else
			$display("** signed_integer_to_radix_text_core: FAILED **");
		$finish;
	end

endmodule

// ===== filelist.f =====
rtl/sirt_pkg.sv
rtl/sirt_div.sv
rtl/signed_integer_to_radix_text_core.sv
test/tb_top.sv
